FILE: hw/rtl/igm_pkg.sv
// ----------------------------------------------------------------------------
// igm_pkg
// Shared types, codes and helper functions of the gradient map unit.
// ----------------------------------------------------------------------------
package igm_pkg;

  localparam int DATA_W      = 32;
  localparam int TDATA_W     = 136;
  localparam int DIV_STEPS   = 31;

  // Operation codes carried by the input request.
  localparam logic [1:0] OP_VERTEX  = 2'd0;
  localparam logic [1:0] OP_DERIV   = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_UNSUP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORDER  = 2'd0;
  localparam logic [1:0] CFG_VCOUNT = 2'd1;
  localparam logic [1:0] CFG_DIM    = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_START, DP_RD_A, DP_RD_B, DP_XCOL, DP_JMUL, DP_JACC,
    DP_JFIN, DP_CSET, DP_PMUL, DP_PACC, DP_DMUL, DP_DACC, DP_DCHK, DP_DW,
    DP_DIVI, DP_DIVS, DP_DIVW, DP_GRD, DP_GRD2, DP_GMUL, DP_GACC, DP_OUT,
    DP_ERR
  } dp_op_t;

  typedef struct packed {
    logic       cap;
    dp_op_t     op;
    logic [3:0] node;
    logic [1:0] vaddr;
    logic       mid;
    logic [1:0] row;
    logic [1:0] col;
    logic [3:0] ent;
    logic [1:0] code;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic det_nonpos;
  } dp_sts_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic [3:0] d;
  } cof_src_t;

  // Cofactor (i,j) of a row-major 3x3 matrix is J[a]*J[b] - J[c]*J[d].
  function automatic cof_src_t cof_src(input logic [3:0] e);
    cof_src_t s;
    case (e)
      4'd0: s = '{4'd4, 4'd8, 4'd5, 4'd7};
      4'd1: s = '{4'd5, 4'd6, 4'd3, 4'd8};
      4'd2: s = '{4'd3, 4'd7, 4'd4, 4'd6};
      4'd3: s = '{4'd7, 4'd2, 4'd8, 4'd1};
      4'd4: s = '{4'd8, 4'd0, 4'd6, 4'd2};
      4'd5: s = '{4'd6, 4'd1, 4'd7, 4'd0};
      4'd6: s = '{4'd1, 4'd5, 4'd2, 4'd4};
      4'd7: s = '{4'd2, 4'd3, 4'd0, 4'd5};
      4'd8: s = '{4'd0, 4'd4, 4'd1, 4'd3};
      default: s = '{4'd0, 4'd0, 4'd0, 4'd0};
    endcase
    return s;
  endfunction

  // First and second vertex of an edge in canonical order.
  function automatic logic [1:0] edge_a(input logic [2:0] nv, input logic [2:0] e);
    logic [1:0] v;
    if (nv == 3'd4) begin
      case (e)
        3'd3, 3'd4: v = 2'd1;
        3'd5:       v = 2'd2;
        default:    v = 2'd0;
      endcase
    end else begin
      case (e)
        3'd1:    v = 2'd1;
        3'd2:    v = 2'd2;
        default: v = 2'd0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [1:0] edge_b(input logic [2:0] nv, input logic [2:0] e);
    logic [1:0] v;
    if (nv == 3'd4) begin
      case (e)
        3'd1, 3'd3: v = 2'd2;
        3'd2, 3'd4, 3'd5: v = 2'd3;
        default: v = 2'd1;
      endcase
    end else begin
      case (e)
        3'd1:    v = 2'd2;
        3'd2:    v = 2'd0;
        default: v = 2'd1;
      endcase
    end
    return v;
  endfunction

  function automatic logic [3:0] node_count(input logic [1:0] order, input logic [2:0] nv);
    logic [3:0] n;
    if (order == 2'd1) begin
      n = {1'b0, nv};
    end else begin
      case (nv)
        3'd2:    n = 4'd3;
        3'd3:    n = 4'd6;
        default: n = 4'd10;
      endcase
    end
    return n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/igm_ram.sv
// ----------------------------------------------------------------------------
// igm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module igm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hw/rtl/igm_datapath.sv
// ----------------------------------------------------------------------------
// igm_datapath
// Stores, three multiplier lanes, accumulators and the bit-serial divider.
// ----------------------------------------------------------------------------
module igm_datapath #(
  parameter int MAX_NODES = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  igm_pkg::dp_cmd_t    cmd,
  input  logic [1:0]          in_op,
  input  logic [3:0]          in_node_index,
  input  logic signed [31:0]  in_val_a,
  input  logic signed [31:0]  in_val_b,
  input  logic signed [31:0]  in_val_c,
  input  logic signed [31:0]  in_quad_weight,
  input  logic [1:0]          cfg_dim,
  output igm_pkg::dp_sts_t    sts,
  output logic [3:0]          res_node,
  output logic signed [31:0]  res_grad_x,
  output logic signed [31:0]  res_grad_y,
  output logic signed [31:0]  res_grad_z,
  output logic signed [31:0]  res_dtw,
  output logic [1:0]          res_status,
  output logic                res_last
);

  localparam int NW  = 33 + FRAC_BITS;
  localparam int DAW = $clog2(MAX_NODES);

  logic [1:0]         cap_op_r;
  logic [3:0]         cap_idx_r;
  logic [95:0]        cap_v_r;
  logic signed [31:0] w_r;

  logic               vram_we, dram_we;
  logic [95:0]        vram_q, dram_q;

  logic signed [31:0] xa_r [3];
  logic signed [31:0] xcol_r [3];
  logic signed [31:0] drow_r [3];
  logic signed [32:0] opa [3];
  logic signed [32:0] opb [3];
  logic signed [65:0] prod_r [3];
  logic signed [63:0] fl [3];
  logic signed [63:0] acc_r [9];
  logic signed [31:0] jreg_r [9];
  logic signed [32:0] cof_r [9];
  logic signed [31:0] inv_r [9];
  logic signed [63:0] gacc_r [3];
  logic signed [31:0] det_r, dw_r;

  logic [30:0]        rem_r, low_r, q_r;
  logic               neg_r, sat_r;

  igm_pkg::cof_src_t  src;
  logic [3:0]         rbase, rc_idx, cr_idx;
  logic signed [NW-1:0] numer;
  logic [NW-1:0]      mag;
  logic [31:0]        rem2;
  logic [31:0]        qx;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_op_r  <= in_op;
      cap_idx_r <= in_node_index;
      cap_v_r   <= {in_val_c, in_val_b, in_val_a};
      w_r       <= in_quad_weight;
    end
  end

  assign vram_we = (cmd.op == igm_pkg::DP_LOAD) && (cap_op_r == igm_pkg::OP_VERTEX) &&
                   (cap_idx_r < 4'd4);
  assign dram_we = (cmd.op == igm_pkg::DP_LOAD) && (cap_op_r == igm_pkg::OP_DERIV) &&
                   (int'(cap_idx_r) < MAX_NODES);

  igm_ram #(.WIDTH(96), .DEPTH(4)) u_vertex_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (cap_idx_r[1:0]),
    .wdata (cap_v_r),
    .raddr (cmd.vaddr),
    .rdata (vram_q)
  );

  igm_ram #(.WIDTH(96), .DEPTH(MAX_NODES)) u_deriv_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (cap_idx_r[DAW-1:0]),
    .wdata (cap_v_r),
    .raddr (cmd.node[DAW-1:0]),
    .rdata (dram_q)
  );

  assign src    = igm_pkg::cof_src(cmd.ent);
  assign rbase  = {cmd.row, 2'b00} - {2'b00, cmd.row};
  assign rc_idx = rbase + {2'b00, cmd.col};
  assign cr_idx = {cmd.col, 2'b00} - {2'b00, cmd.col} + {2'b00, cmd.row};

  // Divider operands: numerator is cofactor(col,row) scaled by one.
  assign numer = {cof_r[cr_idx], {FRAC_BITS{1'b0}}};
  assign mag   = numer[NW-1] ? NW'(-numer) : NW'(numer);
  assign rem2  = {rem_r, low_r[30]};
  assign qx    = {1'b0, q_r};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      opa[l] = '0;
      opb[l] = '0;
      fl[l]  = 64'(prod_r[l] >>> FRAC_BITS);
    end
    case (cmd.op)
      igm_pkg::DP_JMUL: begin
        for (int l = 0; l < 3; l++) begin
          opa[l] = 33'(xcol_r[l]);
          opb[l] = 33'(drow_r[cmd.col]);
        end
      end
      igm_pkg::DP_PMUL: begin
        opa[0] = 33'(jreg_r[src.a]);
        opb[0] = 33'(jreg_r[src.b]);
        opa[1] = 33'(jreg_r[src.c]);
        opb[1] = 33'(jreg_r[src.d]);
      end
      igm_pkg::DP_DMUL: begin
        for (int l = 0; l < 3; l++) begin
          opa[l] = 33'(jreg_r[l]);
          opb[l] = cof_r[l];
        end
      end
      igm_pkg::DP_DCHK: begin
        opa[0] = 33'(det_r);
        opb[0] = 33'(w_r);
      end
      igm_pkg::DP_GMUL: begin
        for (int l = 0; l < 3; l++) begin
          opa[l] = 33'(drow_r[cmd.row]);
          opb[l] = 33'(inv_r[rbase + 4'(l)]);
        end
      end
      default: begin
      end
    endcase
  end

  // Jacobian registers are architectural state and clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < 9; e++) jreg_r[e] <= '0;
    end else if (cmd.op == igm_pkg::DP_JFIN) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r < int'(cfg_dim)) && (c < int'(cfg_dim))) begin
            jreg_r[r*3+c] <= igm_pkg::sat32(acc_r[r*3+c]);
          end else begin
            jreg_r[r*3+c] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) prod_r[l] <= opa[l] * opb[l];
    case (cmd.op)
      igm_pkg::DP_START: begin
        for (int e = 0; e < 9; e++) begin
          acc_r[e] <= '0;
          inv_r[e] <= '0;
        end
      end
      igm_pkg::DP_RD_B: begin
        for (int l = 0; l < 3; l++) begin
          xa_r[l]   <= vram_q[l*32 +: 32];
          drow_r[l] <= dram_q[l*32 +: 32];
        end
      end
      igm_pkg::DP_XCOL: begin
        for (int l = 0; l < 3; l++) begin
          logic signed [32:0] s;
          s = 33'(xa_r[l]) + 33'($signed(vram_q[l*32 +: 32]));
          xcol_r[l] <= cmd.mid ? s[32:1] : xa_r[l];
        end
      end
      igm_pkg::DP_JACC: begin
        for (int l = 0; l < 3; l++) begin
          acc_r[4'(l*3) + {2'b00, cmd.col}] <= acc_r[4'(l*3) + {2'b00, cmd.col}] + fl[l];
        end
      end
      igm_pkg::DP_CSET: begin
        for (int e = 0; e < 9; e++) cof_r[e] <= '0;
        if (cfg_dim == 2'd1) begin
          cof_r[0] <= 33'(64'sd1 <<< FRAC_BITS);
          det_r    <= jreg_r[0];
        end else begin
          cof_r[0] <= 33'(jreg_r[4]);
          cof_r[1] <= -33'(jreg_r[3]);
          cof_r[3] <= -33'(jreg_r[1]);
          cof_r[4] <= 33'(jreg_r[0]);
        end
      end
      igm_pkg::DP_PACC: begin
        if (cfg_dim == 2'd2) begin
          det_r <= igm_pkg::sat32(fl[0] - fl[1]);
        end else begin
          cof_r[cmd.ent] <= 33'(igm_pkg::sat32(fl[0] - fl[1]));
        end
      end
      igm_pkg::DP_DACC: begin
        det_r <= igm_pkg::sat32(fl[0] + fl[1] + fl[2]);
      end
      igm_pkg::DP_DW: begin
        dw_r <= igm_pkg::sat32(fl[0]);
      end
      igm_pkg::DP_DIVI: begin
        neg_r <= numer[NW-1];
        sat_r <= 64'(mag) >= {1'b0, det_r, 31'b0};
        rem_r <= 31'(mag >> 31);
        low_r <= mag[30:0];
        q_r   <= '0;
      end
      igm_pkg::DP_DIVS: begin
        low_r <= {low_r[29:0], 1'b0};
        if (rem2 >= $unsigned(det_r)) begin
          rem_r <= 31'(rem2 - $unsigned(det_r));
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= rem2[30:0];
          q_r   <= {q_r[29:0], 1'b0};
        end
      end
      igm_pkg::DP_DIVW: begin
        if (sat_r) begin
          inv_r[rc_idx] <= neg_r ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          inv_r[rc_idx] <= neg_r ? $signed(-qx) : $signed(qx);
        end
      end
      igm_pkg::DP_GRD2: begin
        for (int l = 0; l < 3; l++) begin
          drow_r[l] <= dram_q[l*32 +: 32];
          gacc_r[l] <= '0;
        end
      end
      igm_pkg::DP_GACC: begin
        for (int l = 0; l < 3; l++) gacc_r[l] <= gacc_r[l] + fl[l];
      end
      igm_pkg::DP_OUT: begin
        res_node   <= cmd.node;
        res_grad_x <= igm_pkg::sat32(gacc_r[0]);
        res_grad_y <= igm_pkg::sat32(gacc_r[1]);
        res_grad_z <= igm_pkg::sat32(gacc_r[2]);
        res_dtw    <= dw_r;
        res_status <= igm_pkg::ST_OK;
        res_last   <= cmd.last;
      end
      igm_pkg::DP_ERR: begin
        res_node   <= '0;
        res_grad_x <= '0;
        res_grad_y <= '0;
        res_grad_z <= '0;
        res_dtw    <= '0;
        res_status <= cmd.code;
        res_last   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts.det_nonpos = det_r[31] || (det_r == 32'sd0);

endmodule

FILE: hw/rtl/igm_ctrl.sv
// ----------------------------------------------------------------------------
// igm_ctrl
// Sequencer that walks nodes, cofactors, divisions and results.
// ----------------------------------------------------------------------------
module igm_ctrl #(
  parameter int MAX_NODES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [1:0]       in_op,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic [1:0]       cfg_order,
  input  logic [2:0]       cfg_vcount,
  input  logic [1:0]       cfg_dim,
  input  igm_pkg::dp_sts_t sts,
  output igm_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_CHECK, S_RD_A, S_RD_B, S_XCOL, S_JMUL, S_JACC, S_JFIN,
    S_CSET, S_PMUL, S_PACC, S_DMUL, S_DACC, S_DCHK, S_DW, S_DIVI, S_DIVS,
    S_DIVW, S_GRD, S_GRD2, S_GMUL, S_GACC, S_OUT, S_ERR, S_EMIT
  } state_t;

  state_t     state_r;
  logic [3:0] k_r, e_r;
  logic [1:0] i_r, j_r;
  logic [4:0] s_r;
  logic       err_r;
  logic [1:0] err_code_r;

  logic [3:0] n_cnt;
  logic       mid, last_node, last_i, last_j, unsup;
  logic [2:0] edge_no;

  assign n_cnt     = igm_pkg::node_count(cfg_order, cfg_vcount);
  assign mid       = k_r >= {1'b0, cfg_vcount};
  assign edge_no   = 3'(k_r - {1'b0, cfg_vcount});
  assign last_node = k_r == (n_cnt - 4'd1);
  assign last_i    = i_r == (cfg_dim - 2'd1);
  assign last_j    = j_r == (cfg_dim - 2'd1);
  assign unsup     = (cfg_order != 2'd1 && cfg_order != 2'd2) || (cfg_vcount < 3'd2) ||
                     (cfg_vcount > 3'd4) || (cfg_dim == 2'd0) || (int'(n_cnt) > MAX_NODES);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_EMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      k_r        <= '0;
      e_r        <= '0;
      i_r        <= '0;
      j_r        <= '0;
      s_r        <= '0;
      err_r      <= 1'b0;
      err_code_r <= igm_pkg::ST_OK;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (in_op == igm_pkg::OP_VERTEX || in_op == igm_pkg::OP_DERIV) begin
              state_r <= S_LOAD;
            end else if (in_op == igm_pkg::OP_COMPUTE) begin
              state_r <= S_CHECK;
            end
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_CHECK: begin
          err_r <= 1'b0;
          k_r   <= '0;
          j_r   <= '0;
          if (unsup) begin
            err_code_r <= igm_pkg::ST_UNSUP;
            state_r    <= S_ERR;
          end else begin
            state_r <= S_RD_A;
          end
        end
        S_RD_A: state_r <= S_RD_B;
        S_RD_B: state_r <= S_XCOL;
        S_XCOL: begin
          j_r     <= '0;
          state_r <= S_JMUL;
        end
        S_JMUL: state_r <= S_JACC;
        S_JACC: begin
          if (last_j) begin
            j_r <= '0;
            if (last_node) begin
              state_r <= S_JFIN;
            end else begin
              k_r     <= k_r + 4'd1;
              state_r <= S_RD_A;
            end
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_JMUL;
          end
        end
        S_JFIN: begin
          if (cfg_dim == 2'd3) begin
            e_r     <= 4'd0;
            state_r <= S_PMUL;
          end else if (cfg_dim == 2'd2) begin
            e_r     <= 4'd8;
            state_r <= S_PMUL;
          end else begin
            state_r <= S_CSET;
          end
        end
        S_PMUL: state_r <= S_PACC;
        S_PACC: begin
          if (cfg_dim == 2'd2) begin
            state_r <= S_CSET;
          end else if (e_r == 4'd8) begin
            state_r <= S_DMUL;
          end else begin
            e_r     <= e_r + 4'd1;
            state_r <= S_PMUL;
          end
        end
        S_CSET: state_r <= S_DCHK;
        S_DMUL: state_r <= S_DACC;
        S_DACC: state_r <= S_DCHK;
        S_DCHK: begin
          if (sts.det_nonpos) begin
            err_code_r <= igm_pkg::ST_NONPOS;
            state_r    <= S_ERR;
          end else begin
            state_r <= S_DW;
          end
        end
        S_DW: begin
          i_r     <= '0;
          j_r     <= '0;
          state_r <= S_DIVI;
        end
        S_DIVI: begin
          s_r     <= '0;
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          s_r <= s_r + 5'd1;
          if (s_r == 5'(igm_pkg::DIV_STEPS - 1)) begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (last_j) begin
            j_r <= '0;
            if (last_i) begin
              k_r     <= '0;
              state_r <= S_GRD;
            end else begin
              i_r     <= i_r + 2'd1;
              state_r <= S_DIVI;
            end
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_DIVI;
          end
        end
        S_GRD: state_r <= S_GRD2;
        S_GRD2: begin
          i_r     <= '0;
          state_r <= S_GMUL;
        end
        S_GMUL: state_r <= S_GACC;
        S_GACC: begin
          if (last_i) begin
            state_r <= S_OUT;
          end else begin
            i_r     <= i_r + 2'd1;
            state_r <= S_GMUL;
          end
        end
        S_OUT: state_r <= S_EMIT;
        S_ERR: begin
          err_r   <= 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_tready) begin
            if (err_r || last_node) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 4'd1;
              state_r <= S_GRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = igm_pkg::DP_NOP;
    cmd.node  = k_r;
    cmd.mid   = mid;
    cmd.row   = i_r;
    cmd.col   = j_r;
    cmd.ent   = e_r;
    cmd.code  = err_code_r;
    cmd.last  = last_node;
    cmd.vaddr = k_r[1:0];
    case (state_r)
      S_IDLE:  cmd.cap = in_tvalid;
      S_LOAD:  cmd.op  = igm_pkg::DP_LOAD;
      S_CHECK: cmd.op  = igm_pkg::DP_START;
      S_RD_A: begin
        cmd.op = igm_pkg::DP_RD_A;
        if (mid) cmd.vaddr = igm_pkg::edge_a(cfg_vcount, edge_no);
      end
      S_RD_B: begin
        cmd.op = igm_pkg::DP_RD_B;
        if (mid) cmd.vaddr = igm_pkg::edge_b(cfg_vcount, edge_no);
      end
      S_XCOL:  cmd.op = igm_pkg::DP_XCOL;
      S_JMUL:  cmd.op = igm_pkg::DP_JMUL;
      S_JACC:  cmd.op = igm_pkg::DP_JACC;
      S_JFIN:  cmd.op = igm_pkg::DP_JFIN;
      S_CSET:  cmd.op = igm_pkg::DP_CSET;
      S_PMUL:  cmd.op = igm_pkg::DP_PMUL;
      S_PACC:  cmd.op = igm_pkg::DP_PACC;
      S_DMUL:  cmd.op = igm_pkg::DP_DMUL;
      S_DACC:  cmd.op = igm_pkg::DP_DACC;
      S_DCHK:  cmd.op = igm_pkg::DP_DCHK;
      S_DW:    cmd.op = igm_pkg::DP_DW;
      S_DIVI:  cmd.op = igm_pkg::DP_DIVI;
      S_DIVS:  cmd.op = igm_pkg::DP_DIVS;
      S_DIVW:  cmd.op = igm_pkg::DP_DIVW;
      S_GRD:   cmd.op = igm_pkg::DP_GRD;
      S_GRD2:  cmd.op = igm_pkg::DP_GRD2;
      S_GMUL:  cmd.op = igm_pkg::DP_GMUL;
      S_GACC:  cmd.op = igm_pkg::DP_GACC;
      S_OUT:   cmd.op = igm_pkg::DP_OUT;
      S_ERR:   cmd.op = igm_pkg::DP_ERR;
      default: cmd.op = igm_pkg::DP_NOP;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && in_tvalid && in_op == igm_pkg::OP_COMPUTE) |=> !in_tready)
    else $error("compute request did not leave idle");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVS) |-> (s_r < 5'(igm_pkg::DIV_STEPS)))
    else $error("divider ran past its step count");

  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !err_r) |-> (k_r < n_cnt))
    else $error("result node beyond node count");

endmodule

FILE: hw/rtl/isoparametric_gradient_map_unit.sv
// ----------------------------------------------------------------------------
// isoparametric_gradient_map_unit
// Maps reference shape derivatives of a P1/P2 simplex element to physical
// gradients at one quadrature point, with det(J) times the weight.
// ----------------------------------------------------------------------------
// A compute request with n nodes and dimension d builds the Jacobian, then the
// determinant and weight product, then the d*d inverse entries (one 31-step serial
// divider), then one result per node, each held while the sink stalls. One
// request is handled at a time; the divider dominates a compute request.
// Reset sets order 1, three vertices, dimension 2 and clears the Jacobian.
// ----------------------------------------------------------------------------
module isoparametric_gradient_map_unit #(
  parameter int MAX_NODES = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // tdata fields from bit 0: node_index[4], val_a[32], val_b[32], val_c[32],
  // quad_weight[32], zero fill.
  input  logic [135:0] in_tdata,
  // tuser fields from bit 0: op[2].
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata fields from bit 0: out_node[4], grad_x[32], grad_y[32], grad_z[32],
  // det_times_weight[32], zero fill.
  output logic [135:0] out_tdata,
  // tuser fields from bit 0: status[2].
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [2:0]   cfg_wdata
);

  // Configuration registers; a write to an index beyond the list is dropped.
  logic [1:0] order_r;
  logic [2:0] vcount_r;
  logic [1:0] dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= 2'd1;
      vcount_r <= 3'd3;
      dim_r    <= 2'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        igm_pkg::CFG_ORDER:  order_r  <= cfg_wdata[1:0];
        igm_pkg::CFG_VCOUNT: vcount_r <= cfg_wdata;
        igm_pkg::CFG_DIM:    dim_r    <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  igm_pkg::dp_cmd_t   cmd;
  igm_pkg::dp_sts_t   sts;
  logic [3:0]         res_node;
  logic signed [31:0] res_gx, res_gy, res_gz, res_dtw;
  logic [1:0]         res_status;
  logic               res_last;

  // The controller decides what happens each cycle; the datapath only obeys.
  igm_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_order  (order_r),
    .cfg_vcount (vcount_r),
    .cfg_dim    (dim_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  igm_datapath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_tuser),
    .in_node_index  (in_tdata[3:0]),
    .in_val_a       ($signed(in_tdata[35:4])),
    .in_val_b       ($signed(in_tdata[67:36])),
    .in_val_c       ($signed(in_tdata[99:68])),
    .in_quad_weight ($signed(in_tdata[131:100])),
    .cfg_dim        (dim_r),
    .sts            (sts),
    .res_node       (res_node),
    .res_grad_x     (res_gx),
    .res_grad_y     (res_gy),
    .res_grad_z     (res_gz),
    .res_dtw        (res_dtw),
    .res_status     (res_status),
    .res_last       (res_last)
  );

  // The result register holds steady while the sink stalls.
  assign out_tdata = {4'b0000, res_dtw, res_gz, res_gy, res_gx, res_node};
  assign out_tuser = res_status;
  assign out_tlast = res_last;

endmodule

FILE: verif/tb_isoparametric_gradient_map_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_isoparametric_gradient_map_unit
// Self-checking bench for the gradient map unit. Vertex and derivative loads
// and compute requests are streamed in with random gaps while the result sink
// stalls at random. A built-in fixed-point predictor works out every gradient
// and det*weight result, and each accepted result is compared field by field.
// ----------------------------------------------------------------------------
module tb_isoparametric_gradient_map_unit;

  localparam int FRAC = 16;
  localparam longint ONE_Q = 64'sd65536;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 64;
  localparam int N_DIR = 25;
  localparam int N_PHASE = 12;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_M1 = 32'hffff_0000;
  // Operation code with no meaning; the block ignores it.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // One expected or observed result.
  typedef struct {
    logic [3:0]  node;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic [31:0] dw;
    logic [1:0]  st;
    logic        is_last;
  } grad_res_t;

  // A row of the directed table. Rows with has_typed set carry a typed-in
  // single error result instead of the predicted one.
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] w;
    logic        has_typed;
    logic [1:0]  st;
  } dir_row_t;

  typedef struct {
    logic [2:0] order;
    logic [2:0] vcount;
    logic [2:0] dim;
    int         budget;
  } phase_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [2:0]   cfg_wdata;

  // Predictor copy of the block's configuration and stores.
  logic [1:0] pr_order;
  logic [2:0] pr_vcount;
  logic [1:0] pr_dim;
  longint     pr_vtx [12];
  longint     pr_drv [30];

  grad_res_t  grad_q [$];
  int         errors = 0;
  int         n_sent = 0;
  int         n_res = 0;
  int         n_ok = 0;
  int         n_nonpos = 0;
  int         n_unsup = 0;
  logic       quiet = 1'b0;
  int         sink_stall = 0;
  int         idle_cycles = 0;

  // Canonical edge lists: line and triangle share the first table.
  int tri_a [3] = '{0, 1, 2};
  int tri_b [3] = '{1, 2, 0};
  int tet_a [6] = '{0, 0, 0, 1, 1, 2};
  int tet_b [6] = '{1, 2, 3, 2, 3, 3};

  // Directed table, walked after reset with order 1, three vertices, dim 2.
  dir_row_t dir_tab [0:N_DIR-1] = '{
    '{igm_pkg::OP_VERTEX, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_VERTEX, 4'd1, Q_ONE, 32'h0, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_VERTEX, 4'd2, 32'h0, Q_ONE, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_VERTEX, 4'd3, 32'h0, 32'h0, Q_ONE, 32'hffffffff,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd0, Q_M1, Q_M1, Q_M1, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd1, Q_ONE, 32'h0, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd2, 32'h0, Q_ONE, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd3, 32'h0, 32'h0, Q_ONE, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd4, 32'h7fffffff, 32'h80000000, 32'h12345678, 32'h0,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd5, 32'h80000000, 32'h7fffffff, 32'hedcba987, 32'h0,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd6, 32'h00008000, 32'hffff8000, 32'h0, 32'h0,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd7, 32'h00020000, 32'h0, 32'hfffe0000, 32'h0,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd8, 32'h0, 32'h00018000, 32'h00004000, 32'h0,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd9, Q_M1, Q_ONE, Q_M1, 32'h0, 1'b0, igm_pkg::ST_OK},
    // Out-of-range indexes are ignored, and so is the unused operation code.
    '{igm_pkg::OP_VERTEX, 4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff,
      32'h7fffffff, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_DERIV, 4'd12, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 1'b0, igm_pkg::ST_OK},
    '{OP_RESERVED, 4'd10, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'hffffffff, 32'hffffffff,
      1'b0, igm_pkg::ST_OK},
    // Unit right triangle: identity Jacobian, weight one half and the extremes.
    '{igm_pkg::OP_COMPUTE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h00008000,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_COMPUTE, 4'd7, 32'h0, 32'h0, 32'h0, 32'h7fffffff,
      1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_COMPUTE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h80000000,
      1'b0, igm_pkg::ST_OK},
    // Collinear vertices give a zero determinant, a mirrored one a negative.
    '{igm_pkg::OP_VERTEX, 4'd2, Q_ONE, 32'h0, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_COMPUTE, 4'd0, 32'h0, 32'h0, 32'h0, Q_ONE,
      1'b1, igm_pkg::ST_NONPOS},
    '{igm_pkg::OP_VERTEX, 4'd2, 32'h0, Q_M1, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK},
    '{igm_pkg::OP_COMPUTE, 4'd0, 32'h0, 32'h0, 32'h0, Q_ONE,
      1'b1, igm_pkg::ST_NONPOS},
    '{igm_pkg::OP_VERTEX, 4'd2, 32'h0, Q_ONE, 32'h0, 32'h0, 1'b0, igm_pkg::ST_OK}
  };

  // Settings swept after the directed part; unsupported ones get few requests.
  phase_t phases [0:N_PHASE-1] = '{
    '{3'd0, 3'd3, 3'd2, 4},  '{3'd1, 3'd2, 3'd1, 45}, '{3'd2, 3'd2, 3'd1, 45},
    '{3'd3, 3'd3, 3'd2, 4},  '{3'd1, 3'd4, 3'd3, 45}, '{3'd1, 3'd1, 3'd2, 4},
    '{3'd2, 3'd4, 3'd3, 45}, '{3'd1, 3'd7, 3'd2, 4},  '{3'd1, 3'd3, 3'd3, 45},
    '{3'd2, 3'd3, 3'd0, 4},  '{3'd1, 3'd0, 3'd1, 4},  '{3'd2, 3'd3, 3'd2, 45}
  };

  isoparametric_gradient_map_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Fixed-point helpers of the predictor: floored product and 32-bit clamp.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void push_status(logic [1:0] st);
    grad_res_t r;
    r = '{4'd0, 32'h0, 32'h0, 32'h0, 32'h0, st, 1'b1};
    grad_q.insert(grad_q.size(), r);
  endfunction

  // Works out the results of one compute request from the predictor state.
  function automatic void predict_gradients(logic [31:0] weight);
    longint    xn [3][10];
    longint    jac [3][3];
    longint    cof [3][3];
    longint    inv [3][3];
    longint    det, dw, s;
    int        nv, n, d, ne, ea, eb;
    grad_res_t r;
    if (pr_order < 1 || pr_order > 2 || pr_vcount < 2 || pr_vcount > 4 ||
        pr_dim < 1 || pr_dim > 3) begin
      push_status(igm_pkg::ST_UNSUP);
      return;
    end
    nv = int'(pr_vcount);
    d = int'(pr_dim);
    if (pr_order == 1) n = nv;
    else n = (nv == 2) ? 3 : (nv == 3) ? 6 : 10;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 10; k++) xn[i][k] = 0;
      for (int j = 0; j < 3; j++) begin
        jac[i][j] = 0;
        cof[i][j] = 0;
        inv[i][j] = 0;
      end
    end
    for (int k = 0; k < nv; k++)
      for (int i = 0; i < 3; i++) xn[i][k] = pr_vtx[k*3+i];
    // Second order: edge midpoints follow the vertices in canonical order.
    if (pr_order == 2) begin
      ne = (nv == 2) ? 1 : (nv == 3) ? 3 : 6;
      for (int k = 0; k < ne; k++) begin
        ea = (nv == 4) ? tet_a[k] : tri_a[k];
        eb = (nv == 4) ? tet_b[k] : tri_b[k];
        for (int i = 0; i < 3; i++) xn[i][nv+k] = (xn[i][ea] + xn[i][eb]) >>> 1;
      end
    end
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++) begin
        s = 0;
        for (int k = 0; k < n; k++) s += qmul(xn[i][k], pr_drv[k*3+j]);
        jac[i][j] = clamp32(s);
      end
    if (d == 1) begin
      cof[0][0] = ONE_Q;
      det = jac[0][0];
    end else if (d == 2) begin
      cof[0][0] = jac[1][1];
      cof[0][1] = -jac[1][0];
      cof[1][0] = -jac[0][1];
      cof[1][1] = jac[0][0];
      det = clamp32(qmul(jac[0][0], jac[1][1]) - qmul(jac[0][1], jac[1][0]));
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          cof[i][j] = clamp32(qmul(jac[(i+1)%3][(j+1)%3], jac[(i+2)%3][(j+2)%3]) -
                              qmul(jac[(i+1)%3][(j+2)%3], jac[(i+2)%3][(j+1)%3]));
      det = 0;
      for (int j = 0; j < 3; j++) det += qmul(jac[0][j], cof[0][j]);
      det = clamp32(det);
    end
    if (det <= 0) begin
      push_status(igm_pkg::ST_NONPOS);
      return;
    end
    // SystemVerilog division truncates toward zero, as the block does.
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++) inv[i][j] = clamp32((cof[j][i] * ONE_Q) / det);
    dw = clamp32(qmul(det, longint'($signed(weight))));
    for (int k = 0; k < n; k++) begin
      r.node = k[3:0];
      r.dw = dw[31:0];
      r.st = igm_pkg::ST_OK;
      r.is_last = (k == n - 1);
      for (int j = 0; j < 3; j++) begin
        s = 0;
        if (j < d)
          for (int i = 0; i < d; i++) s += qmul(pr_drv[k*3+i], inv[i][j]);
        s = clamp32(s);
        if (j == 0) r.gx = s[31:0];
        else if (j == 1) r.gy = s[31:0];
        else r.gz = s[31:0];
      end
      grad_q.insert(grad_q.size(), r);
    end
  endfunction

  // Updates the predictor for one accepted request.
  function automatic void predict_request(logic [1:0] op, logic [3:0] idx, logic [31:0] a,
                                          logic [31:0] b, logic [31:0] c, logic [31:0] w);
    case (op)
      igm_pkg::OP_VERTEX: begin
        if (idx < 4) begin
          pr_vtx[idx*3]   = longint'($signed(a));
          pr_vtx[idx*3+1] = longint'($signed(b));
          pr_vtx[idx*3+2] = longint'($signed(c));
        end
      end
      igm_pkg::OP_DERIV: begin
        if (idx < 10) begin
          pr_drv[idx*3]   = longint'($signed(a));
          pr_drv[idx*3+1] = longint'($signed(b));
          pr_drv[idx*3+2] = longint'($signed(c));
        end
      end
      igm_pkg::OP_COMPUTE: predict_gradients(w);
      default: ;
    endcase
  endfunction

  // Drives one request and holds it until the block takes it. Called at a
  // rising edge; returns at the edge where the request was accepted.
  task automatic send_request(logic [1:0] op, logic [3:0] idx, logic [31:0] a,
                              logic [31:0] b, logic [31:0] c, logic [31:0] w,
                              logic typed, logic [1:0] typed_st);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, w, c, b, a, idx};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (typed) begin
      predict_request(igm_pkg::OP_VERTEX, 4'd15, a, b, c, w);
      push_status(typed_st);
    end else begin
      predict_request(op, idx, a, b, c, w);
    end
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (grad_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [2:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    case (index)
      igm_pkg::CFG_ORDER:  pr_order = value[1:0];
      igm_pkg::CFG_VCOUNT: pr_vcount = value;
      igm_pkg::CFG_DIM:    pr_dim = value[1:0];
      default: ;
    endcase
  endtask

  // Random value centered on zero, span given in Q16.16 units.
  function automatic logic [31:0] rand_q(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // One well-formed element: vertices, node derivatives, then one to three
  // quadrature points. Occasionally the values span the whole 32-bit range.
  task automatic send_element();
    int          nv, n;
    logic        wide;
    int unsigned cspan, dspan;
    logic [31:0] w;
    nv = (pr_vcount >= 2 && pr_vcount <= 4) ? int'(pr_vcount) : 3;
    if (pr_order == 2) n = (nv == 2) ? 3 : (nv == 3) ? 6 : 10;
    else n = nv;
    wide = ($urandom_range(0, 7) == 0);
    cspan = wide ? 32'h7fffffff : 32'h0004_0000;
    dspan = wide ? 32'h7fffffff : 32'h0002_0000;
    for (int k = 0; k < nv; k++)
      send_request(igm_pkg::OP_VERTEX, k[3:0], rand_q(cspan), rand_q(cspan),
                   rand_q(cspan), $urandom, 1'b0, igm_pkg::ST_OK);
    for (int k = 0; k < n; k++)
      send_request(igm_pkg::OP_DERIV, k[3:0], rand_q(dspan), rand_q(dspan),
                   rand_q(dspan), $urandom, 1'b0, igm_pkg::ST_OK);
    repeat ($urandom_range(1, 3)) begin
      // Now and then hold off until the block has drained completely.
      if (!quiet && $urandom_range(0, 5) == 0) wait_drained();
      w = ($urandom_range(0, 1) == 0) ? $urandom : rand_q(32'h0001_0000);
      send_request(igm_pkg::OP_COMPUTE, 4'($urandom), $urandom, $urandom, $urandom, w,
                   1'b0, igm_pkg::ST_OK);
    end
  endtask

  // Noise: any operation including the unused code, any index, any values.
  task automatic send_noise();
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    send_request(op, 4'($urandom), $urandom, $urandom, $urandom, $urandom, 1'b0,
                 igm_pkg::ST_OK);
  endtask

  // Result sink: random stall bursts, none in the quiet part.
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      sink_stall <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result checker: every accepted result is matched with the oldest expectation.
  always @(posedge clk) begin
    grad_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_res++;
      if (grad_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got node %0d status %0d",
                 $realtime, out_tdata[3:0], out_tuser);
        errors++;
      end else begin
        e = grad_q.pop_front();
        check_field("out_node", 32'(e.node), 32'(out_tdata[3:0]));
        check_field("grad_x", e.gx, out_tdata[35:4]);
        check_field("grad_y", e.gy, out_tdata[67:36]);
        check_field("grad_z", e.gz, out_tdata[99:68]);
        check_field("det_times_weight", e.dw, out_tdata[131:100]);
        check_field("status", 32'(e.st), 32'(out_tuser));
        check_field("last", 32'(e.is_last), 32'(out_tlast));
        case (e.st)
          igm_pkg::ST_OK:     n_ok++;
          igm_pkg::ST_NONPOS: n_nonpos++;
          default:            n_unsup++;
        endcase
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_isoparametric_gradient_map_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_end;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= igm_pkg::OP_VERTEX;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= igm_pkg::CFG_ORDER;
    cfg_wdata <= 3'd0;
    pr_order  = 2'd1;
    pr_vcount = 3'd3;
    pr_dim    = 2'd2;
    for (int i = 0; i < 12; i++) pr_vtx[i] = 0;
    for (int i = 0; i < 30; i++) pr_drv[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs on the reset configuration and fills every store
    // entry before the first compute, so no unwritten entry is ever read.
    for (int r = 0; r < N_DIR; r++)
      send_request(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].a, dir_tab[r].b,
                   dir_tab[r].c, dir_tab[r].w, dir_tab[r].has_typed, dir_tab[r].st);

    // Random part: one phase per setting, registers written only when idle.
    for (int p = 0; p < N_PHASE; p++) begin
      wait_drained();
      write_reg(igm_pkg::CFG_ORDER, phases[p].order);
      write_reg(igm_pkg::CFG_VCOUNT, phases[p].vcount);
      write_reg(igm_pkg::CFG_DIM, phases[p].dim);
      cfg_wr_en <= 1'b0;
      if (p == N_PHASE - 1) quiet = 1'b1;
      phase_end = n_sent + phases[p].budget;
      while (n_sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_element();
      end
    end

    wait_drained();
    $display("Sent %0d requests over %0d settings; checked %0d results:", n_sent,
             N_PHASE + 1, n_res);
    $display("  %0d gradients, %0d nonpositive determinants, %0d unsupported elements.",
             n_ok, n_nonpos, n_unsup);
    if (errors == 0) begin
      $display("tb_isoparametric_gradient_map_unit OK");
    end else begin
      $display("tb_isoparametric_gradient_map_unit NOT OK");
    end
    $finish;
  end

endmodule
